>>> src/mjt_pkg.sv
// Shared constants for the minimum-jerk trajectory generator.
`default_nettype none
package mjt_pkg;
   localparam int MAX_WAYPOINTS_DEF = 16;

   localparam logic [31:0] DUR_CONST = 32'd378372;   // 5.7735 in Q16.16
   localparam logic [31:0] T_MIN = 32'd52429;        // 0.8 s in Q16.16
   localparam logic [31:0] MAX_ACCEL_RST = 32'd65536;

   localparam logic [2:0] MODE_LOAD  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_TICK  = 3'd2;
   localparam logic [2:0] MODE_CONT  = 3'd3;
   localparam logic [2:0] MODE_ABORT = 3'd4;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RUN  = 2'd1;
   localparam logic [1:0] PH_WAIT = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;
endpackage
`default_nettype wire

>>> src/min_jerk_trajectory_generator.sv
// Multi-segment minimum-jerk trajectory generator, top level.
//
// Input items arrive on req_* (tuser = mode; tdata = value, index, count,
// time_step). Each item produces exactly one result item on rsp_* holding the
// reference position, velocity, acceleration, phase and finished flag.
// max_accel is written over the csr_* port (byte address 0); the user must write it
// only while idle, which the block itself does not enforce. Items are handled one
// at a time by a sequencer around one shared shift-add multiplier, one restoring
// divider (one quotient bit per cycle) and a two-bit-per-cycle square root. Every
// item runs the output computation; an item that loads a segment (start, or
// continue to the next segment) first runs the duration computation as well.
// A result waits in the output register while rsp_tready is low; the next
// item may already be accepted and worked on, and finishes only once the
// output register is free.
// Reset is synchronous: phase idle, all run state zero, max_accel 1.0.
// The waypoint table is not cleared by reset.
`default_nettype none
module min_jerk_trajectory_generator #(
   parameter int MAX_WAYPOINTS = mjt_pkg::MAX_WAYPOINTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [2:0]   req_tuser,     // mode
   input  wire logic [63:0]  req_tdata,     // value, index, count, time_step
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,     // position, velocity, acceleration, phase, finished
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import mjt_pkg::*;

   localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int CW = $clog2(MAX_WAYPOINTS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_APPLY, S_LRD, S_LEND, S_LDQ, S_LMUL, S_LDIV, S_LSQRT, S_LFIN,
      S_OSTART, S_TAU, S_TAUF, S_T2, S_T3, S_T4, S_T5, S_POS, S_VMUL, S_VDIV,
      S_AMUL, S_ADIV1, S_ADIV2, S_ASAT, S_OUT
   } state_type;

   function automatic logic [31:0] sat32(input logic [67:0] mag, input logic neg);
      logic [31:0] r;
      if (neg) begin
         if (mag > 68'h80000000) r = 32'h80000000;
         else r = 32'd0 - mag[31:0];
      end else begin
         if (mag > 68'h7FFFFFFF) r = 32'h7FFFFFFF;
         else r = mag[31:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [2:0]   mode_ff, mode_in;
   logic [31:0]  value_ff, value_in;
   logic [4:0]   count_ff, count_in;
   logic [16:0]  dt_ff, dt_in;
   logic [31:0]  max_accel_ff, max_accel_in;
   logic [IW-1:0] seg_ff, seg_in;
   logic [CW-1:0] wcount_ff, wcount_in;
   logic [1:0]   phase_ff, phase_in;
   logic [31:0]  start_ff, start_in, end_ff, end_in, dur_ff, dur_in, elap_ff, elap_in;
   logic [32:0]  dq_ff, dq_in;
   logic         neg_ff, neg_in, aneg_ff, aneg_in;
   logic [65:0]  mp_ff, mp_in;
   logic [32:0]  mul_a_ff, mul_a_in;
   logic [67:0]  dv_ff, dv_in;
   logic [45:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [63:0]  sqx_ff, sqx_in;
   logic [33:0]  srem_ff, srem_in;
   logic [31:0]  root_ff, root_in;
   logic [30:0]  tau_ff, tau_in, t2_ff, t2_in, t3_ff, t3_in, t4_ff, t4_in;
   logic [31:0]  pos_ff, pos_in, vel_ff, vel_in;
   logic [31:0]  acc_hold_ff, acc_hold_in;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]  out_pos_ff, out_pos_in, out_vel_ff, out_vel_in, out_acc_ff, out_acc_in;
   logic [1:0]   out_phase_ff, out_phase_in;
   logic [31:0]  wp_rd_ff;
   logic [31:0]  wp_mem [MAX_WAYPOINTS];

   logic         req_fire;
   logic         is_mul, is_div;
   logic [33:0]  msum;
   logic [46:0]  dr;
   logic         dge;
   logic [33:0]  rem2, trial;
   logic signed [32:0] diff;
   logic [32:0]  dq_c;
   logic [32:0]  tick_sum;
   logic [31:0]  tick_sat;
   logic [31:0]  cnt_clamp;
   logic [30:0]  t5_c;
   logic signed [39:0] s40, v40, a40, amag;
   logic [39:0]  am2;
   logic [32:0]  s_c, v_c;
   logic [32:0]  pd;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {5'd0, (out_phase_ff == PH_DONE), out_phase_ff,
                       out_acc_ff, out_vel_ff, out_pos_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? max_accel_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == MODE_LOAD && 32'(req_tdata[35:32]) < MAX_WAYPOINTS) begin
         wp_mem[IW'(req_tdata[35:32])] <= req_tdata[31:0];
      end
      wp_rd_ff <= wp_mem[seg_ff];
   end

   always_comb begin
      diff = $signed({end_ff[31], end_ff}) - $signed({start_ff[31], start_ff});
      dq_c = diff[32] ? 33'(-diff) : 33'(diff);

      tick_sum = {1'b0, elap_ff} + {16'd0, dt_ff};
      tick_sat = tick_sum[32] ? 32'hFFFFFFFF : tick_sum[31:0];

      if (count_ff == 5'd0) cnt_clamp = 32'd1;
      else if (32'(count_ff) > MAX_WAYPOINTS) cnt_clamp = 32'(MAX_WAYPOINTS);
      else cnt_clamp = 32'(count_ff);

      msum = {1'b0, mp_ff[65:33]} + (mp_ff[0] ? {1'b0, mul_a_ff} : 34'd0);
      dr = {rem_ff, dv_ff[67]};
      dge = dr >= {1'b0, dvs_ff};
      rem2 = {srem_ff[31:0], sqx_ff[63:62]};
      trial = {root_ff, 2'b01};

      t5_c = mp_ff[60:30];
      pd = mp_ff[62:30];
      s40 = 40'sd10 * $signed({9'd0, t3_ff}) - 40'sd15 * $signed({9'd0, t4_ff})
          + 40'sd6 * $signed({9'd0, t5_c});
      if (s40 < 0) s_c = 33'd0;
      else if (s40 > 40'sd1073741824) s_c = 33'd1073741824;
      else s_c = s40[32:0];
      v40 = 40'sd30 * $signed({9'd0, t2_ff}) - 40'sd60 * $signed({9'd0, t3_ff})
          + 40'sd30 * $signed({9'd0, t4_ff});
      v_c = (v40 < 0) ? 33'd0 : v40[32:0];
      a40 = 40'sd60 * $signed({9'd0, tau_ff}) - 40'sd180 * $signed({9'd0, t2_ff})
          + 40'sd120 * $signed({9'd0, t3_ff});
      amag = (a40 < 0) ? -a40 : a40;
      am2 = (40'(amag) + 40'd2) >> 2;

      case (state_ff)
         S_LMUL, S_T2, S_T3, S_T4, S_T5, S_POS, S_VMUL, S_AMUL: is_mul = 1'b1;
         default: is_mul = 1'b0;
      endcase
      case (state_ff)
         S_LDIV, S_TAU, S_VDIV, S_ADIV1, S_ADIV2: is_div = 1'b1;
         default: is_div = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      mode_in = mode_ff;
      value_in = value_ff;
      count_in = count_ff;
      dt_in = dt_ff;
      max_accel_in = max_accel_ff;
      seg_in = seg_ff;
      wcount_in = wcount_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      end_in = end_ff;
      dur_in = dur_ff;
      elap_in = elap_ff;
      dq_in = dq_ff;
      neg_in = neg_ff;
      aneg_in = aneg_ff;
      mp_in = mp_ff;
      mul_a_in = mul_a_ff;
      dv_in = dv_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      sqx_in = sqx_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      tau_in = tau_ff;
      t2_in = t2_ff;
      t3_in = t3_ff;
      t4_in = t4_ff;
      pos_in = pos_ff;
      vel_in = vel_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      out_pos_in = out_pos_ff;
      out_vel_in = out_vel_ff;
      out_acc_in = out_acc_ff;
      out_phase_in = out_phase_ff;

      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[2] == 1'b0) begin
         max_accel_in = csr_pwdata;
      end
      if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_in = 1'b0;

      if (cnt_ff != 7'd0) begin
         cnt_in = cnt_ff - 7'd1;
         if (is_mul) mp_in = {msum, mp_ff[32:1]};
         if (is_div) begin
            rem_in = dge ? 46'(dr - {1'b0, dvs_ff}) : dr[45:0];
            dv_in = {dv_ff[66:0], dge};
         end
         if (state_ff == S_LSQRT) begin
            sqx_in = {sqx_ff[61:0], 2'b00};
            if (rem2 >= trial) begin
               srem_in = rem2 - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = rem2;
               root_in = {root_ff[30:0], 1'b0};
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in = req_tuser;
               value_in = req_tdata[31:0];
               count_in = req_tdata[40:36];
               dt_in = req_tdata[57:41];
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = S_OSTART;
            case (mode_ff)
               MODE_START: begin
                  wcount_in = CW'(cnt_clamp);
                  seg_in = '0;
                  start_in = value_ff;
                  phase_in = PH_RUN;
                  state_in = S_LRD;
               end
               MODE_TICK: begin
                  if (phase_ff == PH_RUN) begin
                     if (tick_sat >= dur_ff) begin
                        elap_in = dur_ff;
                        start_in = end_ff;
                        phase_in = PH_WAIT;
                     end else begin
                        elap_in = tick_sat;
                     end
                  end
               end
               MODE_CONT: begin
                  if (phase_ff == PH_WAIT) begin
                     if (32'(seg_ff) + 32'd1 >= 32'(wcount_ff)) begin
                        phase_in = PH_DONE;
                     end else begin
                        seg_in = seg_ff + IW'(1);
                        phase_in = PH_RUN;
                        state_in = S_LRD;
                     end
                  end
               end
               MODE_ABORT: begin
                  seg_in = '0;
                  wcount_in = '0;
                  phase_in = PH_IDLE;
                  start_in = '0;
                  end_in = '0;
                  dur_in = '0;
                  elap_in = '0;
               end
               default: ;
            endcase
         end
         S_LRD: state_in = S_LEND;
         S_LEND: begin
            end_in = wp_rd_ff;
            elap_in = '0;
            state_in = S_LDQ;
         end
         S_LDQ: begin
            dq_in = dq_c;
            if (max_accel_ff == 32'd0) begin
               dur_in = 32'hFFFFFFFF;
               state_in = S_OSTART;
            end else begin
               state_in = S_LMUL;
            end
         end
         S_LMUL: begin
            if (cnt_ff == 7'd0) begin
               mul_a_in = 33'(DUR_CONST);
               mp_in = {33'd0, dq_ff};
               cnt_in = 7'd33;
            end else if (cnt_ff == 7'd1) state_in = S_LDIV;
         end
         S_LDIV: begin
            if (cnt_ff == 7'd0) begin
               dv_in = {mp_ff[51:0], 16'd0};
               dvs_in = {14'd0, max_accel_ff};
               rem_in = '0;
               cnt_in = 7'd68;
            end else if (cnt_ff == 7'd1) state_in = S_LSQRT;
         end
         S_LSQRT: begin
            if (cnt_ff == 7'd0) begin
               if (dv_ff[67:64] != 4'd0) begin
                  dur_in = 32'hFFFFFFFF;
                  state_in = S_OSTART;
               end else begin
                  sqx_in = dv_ff[63:0];
                  srem_in = '0;
                  root_in = '0;
                  cnt_in = 7'd32;
               end
            end else if (cnt_ff == 7'd1) state_in = S_LFIN;
         end
         S_LFIN: begin
            dur_in = (root_ff < T_MIN) ? T_MIN : root_ff;
            state_in = S_OSTART;
         end
         S_OSTART: begin
            dq_in = dq_c;
            neg_in = diff[32];
            if (dur_ff == 32'd0) begin
               tau_in = '0;
               state_in = S_T2;
            end else begin
               state_in = S_TAU;
            end
         end
         S_TAU: begin
            if (cnt_ff == 7'd0) begin
               dv_in = {elap_ff, 36'd0};
               dvs_in = {14'd0, dur_ff};
               rem_in = '0;
               cnt_in = 7'd62;
            end else if (cnt_ff == 7'd1) state_in = S_TAUF;
         end
         S_TAUF: begin
            tau_in = (dv_ff > 68'd1073741824) ? 31'd1073741824 : dv_ff[30:0];
            state_in = S_T2;
         end
         S_T2: begin
            if (cnt_ff == 7'd0) begin
               mul_a_in = {2'd0, tau_ff};
               mp_in = {35'd0, tau_ff};
               cnt_in = 7'd33;
            end else if (cnt_ff == 7'd1) state_in = S_T3;
         end
         S_T3: begin
            if (cnt_ff == 7'd0) begin
               t2_in = mp_ff[60:30];
               mul_a_in = {2'd0, mp_ff[60:30]};
               mp_in = {35'd0, tau_ff};
               cnt_in = 7'd33;
            end else if (cnt_ff == 7'd1) state_in = S_T4;
         end
         S_T4: begin
            if (cnt_ff == 7'd0) begin
               t3_in = mp_ff[60:30];
               mul_a_in = {2'd0, mp_ff[60:30]};
               mp_in = {35'd0, tau_ff};
               cnt_in = 7'd33;
            end else if (cnt_ff == 7'd1) state_in = S_T5;
         end
         S_T5: begin
            if (cnt_ff == 7'd0) begin
               t4_in = mp_ff[60:30];
               mul_a_in = {2'd0, mp_ff[60:30]};
               mp_in = {35'd0, tau_ff};
               cnt_in = 7'd33;
            end else if (cnt_ff == 7'd1) state_in = S_POS;
         end
         S_POS: begin
            if (cnt_ff == 7'd0) begin
               mul_a_in = dq_ff;
               mp_in = {33'd0, s_c};
               cnt_in = 7'd33;
            end else if (cnt_ff == 7'd1) state_in = S_VMUL;
         end
         S_VMUL: begin
            if (cnt_ff == 7'd0) begin
               pos_in = neg_ff ? start_ff - pd[31:0] : start_ff + pd[31:0];
               if (dur_ff == 32'd0) begin
                  vel_in = '0;
                  out_acc_in = out_acc_ff;
                  state_in = S_ASAT;
                  dv_in = '0;
               end else begin
                  mul_a_in = dq_ff;
                  mp_in = {33'd0, v_c};
                  cnt_in = 7'd33;
               end
            end else if (cnt_ff == 7'd1) state_in = S_VDIV;
         end
         S_VDIV: begin
            if (cnt_ff == 7'd0) begin
               dv_in = {mp_ff[63:0], 4'd0};
               dvs_in = {dur_ff, 14'd0};
               rem_in = '0;
               cnt_in = 7'd64;
            end else if (cnt_ff == 7'd1) state_in = S_AMUL;
         end
         S_AMUL: begin
            if (cnt_ff == 7'd0) begin
               vel_in = sat32(dv_ff, neg_ff);
               aneg_in = (a40 < 0);
               mul_a_in = dq_ff;
               mp_in = {33'd0, am2[32:0]};
               cnt_in = 7'd33;
            end else if (cnt_ff == 7'd1) state_in = S_ADIV1;
         end
         S_ADIV1: begin
            if (cnt_ff == 7'd0) begin
               dv_in = {mp_ff[63:0], 4'd0};
               dvs_in = {14'd0, dur_ff};
               rem_in = '0;
               cnt_in = 7'd64;
            end else if (cnt_ff == 7'd1) state_in = S_ADIV2;
         end
         S_ADIV2: begin
            if (cnt_ff == 7'd0) begin
               dv_in = {dv_ff[63:0], 4'd0};
               dvs_in = {2'd0, dur_ff, 12'd0};
               rem_in = '0;
               cnt_in = 7'd64;
            end else if (cnt_ff == 7'd1) state_in = S_ASAT;
         end
         S_ASAT: begin
            state_in = S_OUT;
            dv_in = dv_ff;
            vel_in = vel_ff;
            out_pos_in = out_pos_ff;
            mp_in = mp_ff;
            aneg_in = aneg_ff;
            mul_a_in = mul_a_ff;
            dvs_in = dvs_ff;
            rem_in = rem_ff;
            t2_in = t2_ff;
            t3_in = t3_ff;
            t4_in = t4_ff;
            tau_in = tau_ff;
            pos_in = pos_ff;
            root_in = root_ff;
            srem_in = srem_ff;
            sqx_in = sqx_ff;
            dq_in = dq_ff;
            neg_in = neg_ff;
            dt_in = dt_ff;
            count_in = count_ff;
            value_in = value_ff;
            mode_in = mode_ff;
            out_vel_in = out_vel_ff;
            out_phase_in = out_phase_ff;
            cnt_in = cnt_ff;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_pos_in = pos_ff;
               out_vel_in = vel_ff;
               out_acc_in = acc_hold_ff;
               out_phase_in = phase_ff;
               rsp_tvalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         max_accel_ff <= MAX_ACCEL_RST;
         seg_ff <= '0;
         wcount_ff <= '0;
         phase_ff <= PH_IDLE;
         start_ff <= '0;
         end_ff <= '0;
         dur_ff <= '0;
         elap_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         max_accel_ff <= max_accel_in;
         seg_ff <= seg_in;
         wcount_ff <= wcount_in;
         phase_ff <= phase_in;
         start_ff <= start_in;
         end_ff <= end_in;
         dur_ff <= dur_in;
         elap_ff <= elap_in;
      end
      mode_ff <= mode_in;
      value_ff <= value_in;
      count_ff <= count_in;
      dt_ff <= dt_in;
      dq_ff <= dq_in;
      neg_ff <= neg_in;
      aneg_ff <= aneg_in;
      mp_ff <= mp_in;
      mul_a_ff <= mul_a_in;
      dv_ff <= dv_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sqx_ff <= sqx_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      tau_ff <= tau_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      t4_ff <= t4_in;
      pos_ff <= pos_in;
      vel_ff <= vel_in;
      acc_hold_ff <= acc_hold_in;
      out_pos_ff <= out_pos_in;
      out_vel_ff <= out_vel_in;
      out_acc_ff <= out_acc_in;
      out_phase_ff <= out_phase_in;
   end

   always_comb begin
      acc_hold_in = acc_hold_ff;
      if (state_ff == S_ASAT) acc_hold_in = sat32(dv_ff, neg_ff ^ aneg_ff);
      else if (state_ff == S_VMUL && cnt_ff == 7'd0 && dur_ff == 32'd0) acc_hold_in = '0;
   end

   a_elap_le_dur: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (elap_ff <= dur_ff))
      else $error("elapsed time beyond segment duration");

   a_seg_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (32'(seg_ff) < 32'(wcount_ff)))
      else $error("segment index beyond waypoint count");

   a_dur_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && phase_ff != PH_IDLE) |-> (dur_ff >= T_MIN))
      else $error("active segment shorter than minimum duration");

endmodule
`default_nettype wire

>>> tb/tb_min_jerk_trajectory_generator.sv
// Self-checking testbench for the minimum-jerk trajectory generator: directed table plus random.
module tb_min_jerk_trajectory_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import mjt_pkg::*;

   localparam logic [2:0] MODE_SPARE5 = 3'd5;
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;
   localparam logic [2:0] ADDR_MAX_ACCEL = 3'd0;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 800;
   localparam int ITEMS_PER_SETTING = 110;

   typedef struct packed {
      logic        fin;
      logic [1:0]  phase;
      logic [31:0] acc;
      logic [31:0] vel;
      logic [31:0] pos;
   } traj_out_type;

   typedef struct {
      logic [2:0]  mode;
      logic [31:0] value;
      logic [3:0]  idx;
      logic [4:0]  cnt;
      logic [16:0] ts;
      bit          typed;
      traj_out_type want;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [2:0] req_tuser = '0;     // mode
   logic [63:0] req_tdata = '0;    // value, index, count, time_step
   logic rsp_tvalid;
   logic rsp_tready = 1;
   logic [103:0] rsp_tdata;        // position, velocity, acceleration, phase, finished
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   min_jerk_trajectory_generator dut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic signed [31:0] wp_table [16];
   logic [3:0]  seg_idx;
   logic [4:0]  wp_count;
   logic [1:0]  run_ph;
   logic signed [31:0] seg_start, seg_end;
   logic [31:0] seg_dur, seg_elapsed, accel_limit;

   traj_out_type expected_q[$];
   int errors = 0, mismatches = 0, items_sent = 0, results_seen = 0;
   int starts = 0, waits_hit = 0, dones_hit = 0;
   int cycles = 0;
   bit quiet_idle = 0;
   int rsp_stall = 0;

   function automatic logic [63:0] isqrt64(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] span(logic signed [31:0] a, logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? 64'(-d) : 64'(d);
   endfunction

   function automatic logic [31:0] sat32(logic [63:0] mag, bit neg);
      if (neg) begin
         if (mag > 64'h8000_0000) mag = 64'h8000_0000;
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return mag[31:0];
   endfunction

   task automatic begin_segment();
      logic [63:0] dq, num, hi, lo, t;
      seg_end = wp_table[seg_idx];
      seg_elapsed = 0;
      dq = span(seg_end, seg_start);
      if (accel_limit == 0) begin
         seg_dur = '1;
         return;
      end
      num = 64'(DUR_CONST) * dq;
      hi = num / accel_limit;
      if (hi >= (64'd1 << 48)) begin
         seg_dur = '1;
         return;
      end
      lo = ((num % accel_limit) << 16) / accel_limit;
      t = isqrt64((hi << 16) | lo);
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      if (t < T_MIN) t = T_MIN;
      seg_dur = t[31:0];
   endtask

   function automatic traj_out_type ref_point();
      traj_out_type o;
      logic [63:0] tau, t2, t3, t4, t5, dq, d, am;
      longint s, v, a, p;
      bit neg, aneg;
      neg = seg_end < seg_start;
      dq = span(seg_end, seg_start);
      tau = 0;
      if (seg_dur != 0) begin
         tau = (64'(seg_elapsed) << 30) / seg_dur;
         if (tau > (64'd1 << 30)) tau = 64'd1 << 30;
      end
      t2 = (tau * tau) >> 30;
      t3 = (t2 * tau) >> 30;
      t4 = (t3 * tau) >> 30;
      t5 = (t4 * tau) >> 30;
      s = 10 * longint'(t3) - 15 * longint'(t4) + 6 * longint'(t5);
      if (s < 0) s = 0;
      if (s > (longint'(1) << 30)) s = longint'(1) << 30;
      d = (dq * 64'(s)) >> 30;
      p = neg ? longint'(seg_start) - longint'(d) : longint'(seg_start) + longint'(d);
      o.pos = p[31:0];
      if (seg_dur == 0) begin
         o.vel = 0;
         o.acc = 0;
      end else begin
         v = 30 * longint'(t2) - 60 * longint'(t3) + 30 * longint'(t4);
         if (v < 0) v = 0;
         d = (dq * 64'(v)) / (64'(seg_dur) << 14);
         o.vel = sat32(d, neg);
         a = 60 * longint'(tau) - 180 * longint'(t2) + 120 * longint'(t3);
         aneg = a < 0;
         am = aneg ? 64'(-a) : 64'(a);
         am = (am + 2) >> 2;
         d = (dq * am) / seg_dur;
         d = d / (64'(seg_dur) << 12);
         o.acc = sat32(d, neg != aneg);
      end
      o.phase = run_ph;
      o.fin = run_ph == PH_DONE;
      return o;
   endfunction

   task automatic clear_run();
      seg_idx = 0;
      wp_count = 0;
      run_ph = PH_IDLE;
      seg_start = 0;
      seg_end = 0;
      seg_dur = 0;
      seg_elapsed = 0;
   endtask

   task automatic traj_apply(logic [2:0] mode, logic [31:0] value, logic [3:0] idx,
                             logic [4:0] cnt, logic [16:0] ts);
      logic [32:0] sum;
      case (mode)
         MODE_LOAD: wp_table[idx] = value;
         MODE_START: begin
            wp_count = (cnt == 0) ? 5'd1 : (cnt > 16) ? 5'd16 : cnt;
            seg_idx = 0;
            seg_start = value;
            run_ph = PH_RUN;
            starts++;
            begin_segment();
         end
         MODE_TICK: if (run_ph == PH_RUN) begin
            sum = 33'(seg_elapsed) + 33'(ts);
            seg_elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (seg_elapsed >= seg_dur) begin
               seg_elapsed = seg_dur;
               seg_start = seg_end;
               run_ph = PH_WAIT;
               waits_hit++;
            end
         end
         MODE_CONT: if (run_ph == PH_WAIT) begin
            if (5'(seg_idx) + 5'd1 >= wp_count) begin
               run_ph = PH_DONE;
               dones_hit++;
            end else begin
               seg_idx++;
               begin_segment();
               run_ph = PH_RUN;
            end
         end
         MODE_ABORT: clear_run();
         default: ;
      endcase
   endtask

   function automatic int draw_gap();
      return quiet_idle ? 0 : $urandom_range(0, 6);
   endfunction

   task automatic send_item(logic [2:0] mode, logic [31:0] value, logic [3:0] idx,
                            logic [4:0] cnt, logic [16:0] ts, bit typed, traj_out_type want);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= mode;
      req_tdata <= {6'b0, ts, cnt, idx, value};
      do @(posedge clock); while (!req_tready);
      traj_apply(mode, value, idx, cnt, ts);
      expected_q.push_back(typed ? want : ref_point());
      items_sent++;
   endtask

   task automatic send(logic [2:0] mode, logic [31:0] value, logic [3:0] idx,
                       logic [4:0] cnt, logic [16:0] ts);
      send_item(mode, value, idx, cnt, ts, 0, '0);
   endtask

   task automatic write_accel(logic [31:0] val);
      req_tvalid <= 0;
      wait (expected_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= ADDR_MAX_ACCEL;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      accel_limit = val;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pos();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom;
      if (r < 3) return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
      return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
   endfunction

   function automatic logic [16:0] rand_step();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 17'h1_0000;
      if (r == 1) return 17'($urandom_range(0, 16));
      return 17'($urandom_range(0, 65536));
   endfunction

   task automatic random_phase(int target);
      int stop_at, n, k;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 60) begin
            n = $urandom_range(0, 3);
            repeat (n) send(MODE_LOAD, rand_pos(), 4'($urandom_range(0, 3)), 0, 0);
            send(MODE_START, rand_pos(), 4'($urandom),
                 ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4)),
                 17'($urandom));
            while (run_ph == PH_RUN || run_ph == PH_WAIT) begin
               k = 0;
               while (run_ph == PH_RUN && k < 12) begin
                  send(MODE_TICK, $urandom, 4'($urandom), 5'($urandom), rand_step());
                  k++;
               end
               if (run_ph == PH_RUN || $urandom_range(0, 9) == 0) break;
               send(MODE_CONT, $urandom, 4'($urandom), 5'($urandom), 17'($urandom));
            end
         end else begin
            send(3'($urandom), ($urandom_range(0, 1) != 0) ? rand_pos() : $urandom,
                 4'($urandom), 5'($urandom), 17'($urandom));
         end
      end
   endtask

   stim_row_type rows[] = '{
      '{MODE_TICK,   32'h0,        4'd0,  5'd0,  17'h1_0000, 1, '0},
      '{MODE_CONT,   32'hFFFF_FFFF, 4'hF, 5'h1F, 17'h1_FFFF, 1, '0},
      '{MODE_SPARE5, 32'h1234_5678, 4'd3, 5'd3,  17'd5,      1, '0},
      '{MODE_SPARE6, 32'h0,        4'd0,  5'd0,  17'd0,      1, '0},
      '{MODE_SPARE7, 32'hFFFF_FFFF, 4'hF, 5'h1F, 17'h1_FFFF, 1, '0},
      '{MODE_ABORT,  32'h0,        4'd0,  5'd0,  17'd0,      1, '0},
      '{MODE_LOAD,   32'h7FFF_FFFF, 4'd0, 5'd0,  17'd0,      1, '0},
      '{MODE_LOAD,   32'h8000_0000, 4'hF, 5'd0,  17'd0,      1, '0},
      '{MODE_START,  32'h8000_0000, 4'd0, 5'd0,  17'd0,      0, '0},
      '{MODE_TICK,   32'h0,        4'd0,  5'd0,  17'd0,      0, '0},
      '{MODE_TICK,   32'h0,        4'd0,  5'd0,  17'h1_0000, 0, '0},
      '{MODE_CONT,   32'h0,        4'd0,  5'd0,  17'd0,      0, '0},
      '{MODE_LOAD,   32'h0001_0000, 4'd1, 5'd0,  17'd0,      0, '0},
      '{MODE_LOAD,   32'hFFFF_8000, 4'd2, 5'd0,  17'd0,      0, '0},
      '{MODE_START,  32'h0001_0000, 4'd0, 5'h1F, 17'd0,      0, '0},
      '{MODE_START,  32'h0,        4'd0,  5'd3,  17'd0,      0, '0},
      '{MODE_TICK,   32'h0,        4'd0,  5'd0,  17'h0_8000, 0, '0},
      '{MODE_TICK,   32'h0,        4'd0,  5'd0,  17'h1_0000, 0, '0},
      '{MODE_TICK,   32'h0,        4'd0,  5'd0,  17'h1_0000, 0, '0},
      '{MODE_CONT,   32'h0,        4'd0,  5'd0,  17'd0,      0, '0},
      '{MODE_TICK,   32'h0,        4'd0,  5'd0,  17'h1_0000, 0, '0},
      '{MODE_CONT,   32'h0,        4'd0,  5'd0,  17'd0,      0, '0},
      '{MODE_ABORT,  32'h0,        4'd0,  5'd0,  17'd0,      1, '0}
   };

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("min_jerk_trajectory_generator regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      traj_out_type got, want;
      int n;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[98:0];
            results_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("result with none pending: %h", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch pos %h/%h vel %h/%h acc %h/%h ph %0d/%0d fin %b/%b",
                              want.pos, got.pos, want.vel, got.vel, want.acc, got.acc,
                              want.phase, got.phase, want.fin, got.fin);
               end
            end
            n = quiet_idle ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
               rsp_tready <= 0;
               rsp_stall <= n;
            end
         end else if (!rsp_tready) begin
            if (rsp_stall <= 1) rsp_tready <= 1;
            rsp_stall <= rsp_stall - 1;
         end
      end
   end

   initial begin
      logic [31:0] settings [4];
      int wait_cycles;
      settings = '{32'hFFFF_FFFF, 32'd1, 32'h0003_0000, 32'h0};
      settings[3] = $urandom_range(1, 32'h0010_0000);
      accel_limit = MAX_ACCEL_RST;
      clear_run();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 16; i++) send(MODE_LOAD, rand_pos(), 4'(i), 0, 0);
      foreach (rows[i])
         send_item(rows[i].mode, rows[i].value, rows[i].idx, rows[i].cnt, rows[i].ts,
                   rows[i].typed, rows[i].want);
      write_accel(MAX_ACCEL_RST);
      quiet_idle = 1;
      random_phase(ITEMS_PER_SETTING / 2);
      quiet_idle = 0;
      random_phase(ITEMS_PER_SETTING / 2);
      foreach (settings[i]) begin
         write_accel(settings[i]);
         quiet_idle = (i == 1);
         random_phase(ITEMS_PER_SETTING);
      end
      req_tvalid <= 0;
      wait_cycles = 0;
      while (expected_q.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) errors++;
      $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
               results_seen, mismatches);
      $display("%0d starts, %0d segments reached, %0d runs done, 5 accel settings",
               starts, waits_hit, dones_hit);
      if (errors == 0) begin
         $display("min_jerk_trajectory_generator regression: pass");
      end else begin
         $display("min_jerk_trajectory_generator regression: fail");
      end
      $finish;
   end
endmodule

>>> sim.f
src/mjt_pkg.sv
src/min_jerk_trajectory_generator.sv
tb/tb_min_jerk_trajectory_generator.sv
